>>> hdl/gyt_pkg.sv
// Shared types and constants for the gyro yaw tracker.
// Holds fixed-point formats, datapath command encoding and register map.
// No dependencies.
package gyt_pkg;

    localparam int FRAC_BITS = 16;

    localparam int GYRO_W    = 23;
    localparam int ELAPSED_W = 16;
    localparam int RATE_W    = 29;
    localparam int ANGLE_W   = 25;
    localparam int SMOOTH_W  = 30;
    localparam int GAIN_W    = 17;
    localparam int LIMIT_W   = 28;

    localparam int HALF_TURN = 180 << FRAC_BITS;
    localparam int FULL_TURN = 360 << FRAC_BITS;
    localparam int RATE_MAX  = (4096 << FRAC_BITS) - 1;
    localparam int RATE_MIN  = -(4096 << FRAC_BITS);

    // 180/pi in Q32
    localparam logic [37:0] RAD2DEG_Q32 = 38'd246083499207;
    // ceil(2^38 / 125), divides by 125 after a shift by 3
    localparam logic [31:0] DIV_RECIP   = 32'd2199023256;
    // |p| + 500 at or above this gives an increment beyond a half turn
    localparam logic [33:0] INC_LIMIT   = 34'd11796481000;

    localparam logic [GAIN_W-1:0]  GAIN_ONE  = 17'd65536;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 17'd58982;
    localparam logic [LIMIT_W-1:0] LIMIT_RST =
        LIMIT_W'(((1975 << FRAC_BITS) + 500) / 1000);

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_OFFSET = 2'd0;
    localparam logic [1:0] REG_GAIN   = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;

    typedef struct packed {
        logic [GYRO_W-1:0]  offset;
        logic [GAIN_W-1:0]  gain;
        logic [LIMIT_W-1:0] limit;
    } t_cfg;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_RAD_HI,
        MUL_RAD_LO,
        MUL_PREV,
        MUL_RAW,
        MUL_INC,
        MUL_DIV_HI,
        MUL_DIV_LO
    } t_mul_sel;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_RAD,
        ACC_FILT,
        ACC_DIV,
        ACC_ADD
    } t_acc_op;

    typedef struct packed {
        logic     load;
        logic     clear_head;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     ld_raw;
        logic     ld_smooth;
        logic     ld_x;
        logic     ld_inc;
        logic     ld_head;
    } t_dp_cmd;

endpackage

>>> hdl/gyt_regs.sv
// APB configuration registers: rate offset, smoothing gain, deadzone limit.
// Depends on gyt_pkg.
module gyt_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [gyt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output gyt_pkg::t_cfg             o_cfg
);
    import gyt_pkg::*;

    logic [GYRO_W-1:0]  r_offset;
    logic [GAIN_W-1:0]  r_gain;
    logic [LIMIT_W-1:0] r_limit;
    logic               wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_gain   <= GAIN_RST;
            r_limit  <= LIMIT_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_OFFSET: r_offset <= pwdata[GYRO_W-1:0];
                REG_GAIN:   r_gain   <= pwdata[GAIN_W-1:0];
                REG_LIMIT:  r_limit  <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_OFFSET: prdata = 32'($signed(r_offset));
            REG_GAIN:   prdata = 32'(r_gain);
            REG_LIMIT:  prdata = 32'(r_limit);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = '{offset: r_offset, gain: r_gain, limit: r_limit};

endmodule

>>> hdl/gyt_dp.sv
// Datapath: shared 32x20 multiplier, accumulator, filter and heading registers.
// Driven step by step by gyt_ctrl. Depends on gyt_pkg.
module gyt_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gyt_pkg::t_dp_cmd                    i_cmd,
    input  gyt_pkg::t_cfg                       i_cfg,
    input  logic signed [gyt_pkg::GYRO_W-1:0]   i_gyro_rate,
    input  logic [gyt_pkg::ELAPSED_W-1:0]       i_elapsed_ms,
    output logic signed [gyt_pkg::RATE_W-1:0]   o_turn_rate,
    output logic signed [gyt_pkg::ANGLE_W-1:0]  o_heading
);
    import gyt_pkg::*;

    localparam logic signed [25:0] HALF_S    = 26'(HALF_TURN);
    localparam logic signed [25:0] FULL_S    = 26'(FULL_TURN);
    localparam logic signed [31:0] RAW_MAX_S = 32'(RATE_MAX);
    localparam logic signed [31:0] RAW_MIN_S = 32'(RATE_MIN);
    localparam logic signed [63:0] RND_RAD   = 64'sd2147483648;
    localparam logic signed [63:0] RND_FILT  = 64'sd32768;

    logic signed [GYRO_W:0]     r_diff;
    logic [ELAPSED_W-1:0]       r_elapsed;
    logic signed [RATE_W-1:0]   r_raw;
    logic signed [SMOOTH_W-1:0] r_smooth;
    logic signed [RATE_W-1:0]   r_rate;
    logic [44:0]                r_x;
    logic                       r_neg;
    logic                       r_big;
    logic signed [ANGLE_W-1:0]  r_inc;
    logic signed [ANGLE_W-1:0]  r_head;
    logic signed [52:0]         r_prod;
    logic signed [63:0]         r_acc;
    logic signed [RATE_W-1:0]   r_out_rate;
    logic signed [ANGLE_W-1:0]  r_out_angle;

    logic [GAIN_W-1:0]          g_eff;
    logic [GAIN_W-1:0]          g_rest;
    logic signed [31:0]         mul_a;
    logic [19:0]                mul_b;
    logic signed [63:0]         n_acc;
    logic signed [31:0]         acc_hi;
    logic signed [RATE_W-1:0]   raw_sat;
    logic signed [SMOOTH_W-1:0] smooth_n;
    logic [SMOOTH_W-1:0]        smooth_mag;
    logic                       dz_zero;
    logic [44:0]                x_n;
    logic [23:0]                quot;
    logic [23:0]                inc_mag;
    logic signed [ANGLE_W-1:0]  inc_n;
    logic signed [25:0]         head_sum;
    logic signed [ANGLE_W-1:0]  head_n;

    assign g_eff  = (i_cfg.gain > GAIN_ONE) ? GAIN_ONE : i_cfg.gain;
    assign g_rest = GAIN_ONE - g_eff;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_RAD_HI: begin
                mul_a = 32'(r_diff);
                mul_b = 20'(RAD2DEG_Q32[37:19]);
            end
            MUL_RAD_LO: begin
                mul_a = 32'(r_diff);
                mul_b = 20'(RAD2DEG_Q32[18:0]);
            end
            MUL_PREV: begin
                mul_a = 32'(r_smooth);
                mul_b = 20'(g_eff);
            end
            MUL_RAW: begin
                mul_a = 32'(r_raw);
                mul_b = 20'(g_rest);
            end
            MUL_INC: begin
                mul_a = 32'(r_rate);
                mul_b = 20'(r_elapsed);
            end
            MUL_DIV_HI: begin
                mul_a = $signed({1'b0, r_x[33:3]});
                mul_b = 20'(DIV_RECIP[31:16]);
            end
            MUL_DIV_LO: begin
                mul_a = $signed({1'b0, r_x[33:3]});
                mul_b = 20'(DIV_RECIP[15:0]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.acc_op)
            ACC_RAD:  n_acc = (64'(r_prod) <<< 19) + RND_RAD;
            ACC_FILT: n_acc = 64'(r_prod) + RND_FILT;
            ACC_DIV:  n_acc = 64'(r_prod) <<< 16;
            ACC_ADD:  n_acc = r_acc + 64'(r_prod);
            default:  n_acc = r_acc;
        endcase
    end

    // rad/s to deg/s, rounded, then saturated
    assign acc_hi = r_acc[63:32];
    always_comb begin
        if (acc_hi > RAW_MAX_S) begin
            raw_sat = RATE_W'(RAW_MAX_S);
        end else if (acc_hi < RAW_MIN_S) begin
            raw_sat = RATE_W'(RAW_MIN_S);
        end else begin
            raw_sat = acc_hi[RATE_W-1:0];
        end
    end

    assign smooth_n   = r_acc[45:16];
    assign smooth_mag = smooth_n[SMOOTH_W-1] ? SMOOTH_W'(-smooth_n) : SMOOTH_W'(smooth_n);
    assign dz_zero    = smooth_mag < SMOOTH_W'(i_cfg.limit);

    // |p| + 500; for negative p, ~p + 501
    assign x_n = r_prod[52] ? (~r_prod[44:0]) + 45'd501 : r_prod[44:0] + 45'd500;

    assign quot    = r_acc[61:38];
    assign inc_mag = r_big ? 24'(HALF_TURN) : quot;
    assign inc_n   = r_neg ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});

    assign head_sum = 26'(r_head) + 26'(r_inc);
    always_comb begin
        if (head_sum > HALF_S) begin
            head_n = ANGLE_W'(head_sum - FULL_S);
        end else if (head_sum < -HALF_S) begin
            head_n = ANGLE_W'(head_sum + FULL_S);
        end else begin
            head_n = ANGLE_W'(head_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= '0;
            r_head   <= '0;
        end else begin
            if (i_cmd.ld_smooth) begin
                r_smooth <= smooth_n;
            end
            if (i_cmd.clear_head) begin
                r_head <= '0;
            end else if (i_cmd.ld_head) begin
                r_head <= head_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * $signed({1'b0, mul_b});
        r_acc  <= n_acc;
        if (i_cmd.load) begin
            r_diff    <= (GYRO_W+1)'(i_gyro_rate) - (GYRO_W+1)'($signed(i_cfg.offset));
            r_elapsed <= i_elapsed_ms;
            r_rate    <= '0;
            r_inc     <= '0;
        end
        if (i_cmd.ld_raw) begin
            r_raw <= raw_sat;
        end
        if (i_cmd.ld_smooth) begin
            r_rate <= dz_zero ? '0 : smooth_n[RATE_W-1:0];
        end
        if (i_cmd.ld_x) begin
            r_x   <= x_n;
            r_neg <= r_prod[52];
            r_big <= x_n >= 45'(INC_LIMIT);
        end
        if (i_cmd.ld_inc) begin
            r_inc <= inc_n;
        end
        if (i_cmd.ld_head) begin
            r_out_rate  <= r_rate;
            r_out_angle <= head_n;
        end
    end

    assign o_turn_rate = r_out_rate;
    assign o_heading   = r_out_angle;

`ifndef NO_ASSERTIONS
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (26'(r_head) <= HALF_S) && (26'(r_head) >= -HALF_S))
        else $error("heading left the half-turn range");

    a_head_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_head |=> (r_head == '0))
        else $error("heading not cleared by reset command");

    a_deadzone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ld_smooth |=> ((r_rate == '0) || (r_rate == r_smooth[RATE_W-1:0])))
        else $error("output rate differs from filtered rate");
`endif

endmodule

>>> hdl/gyt_ctrl.sv
// Controller: sequences one item through the shared multiplier and accumulator.
// Owns the input ready and the output valid register. Depends on gyt_pkg.
module gyt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_command,
    input  logic             i_sample_ok,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output gyt_pkg::t_dp_cmd o_cmd
);
    import gyt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RAD_HI,
        S_RAD_LO,
        S_RAD_SUM,
        S_SAT,
        S_FILT_B,
        S_FILT_SUM,
        S_SMOOTH,
        S_INC_MUL,
        S_INC_ABS,
        S_DIV_HI,
        S_DIV_LO,
        S_DIV_SUM,
        S_INC,
        S_HEAD
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    in_xfer;
    logic    out_free;
    t_dp_cmd cmd;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid & o_in_ready;
    assign out_free   = ~r_out_valid | i_out_ready;

    always_comb begin
        cmd         = '0;
        cmd.mul_sel = MUL_NONE;
        cmd.acc_op  = ACC_HOLD;
        n_state     = r_state;
        case (r_state)
            S_IDLE: begin
                cmd.load       = in_xfer;
                cmd.clear_head = in_xfer & i_command;
                if (in_xfer) begin
                    n_state = (i_command | ~i_sample_ok) ? S_HEAD : S_RAD_HI;
                end
            end
            S_RAD_HI: begin
                cmd.mul_sel = MUL_RAD_HI;
                n_state     = S_RAD_LO;
            end
            S_RAD_LO: begin
                cmd.mul_sel = MUL_RAD_LO;
                cmd.acc_op  = ACC_RAD;
                n_state     = S_RAD_SUM;
            end
            S_RAD_SUM: begin
                cmd.acc_op = ACC_ADD;
                n_state    = S_SAT;
            end
            S_SAT: begin
                cmd.ld_raw  = 1'b1;
                cmd.mul_sel = MUL_PREV;
                n_state     = S_FILT_B;
            end
            S_FILT_B: begin
                cmd.mul_sel = MUL_RAW;
                cmd.acc_op  = ACC_FILT;
                n_state     = S_FILT_SUM;
            end
            S_FILT_SUM: begin
                cmd.acc_op = ACC_ADD;
                n_state    = S_SMOOTH;
            end
            S_SMOOTH: begin
                cmd.ld_smooth = 1'b1;
                n_state       = S_INC_MUL;
            end
            S_INC_MUL: begin
                cmd.mul_sel = MUL_INC;
                n_state     = S_INC_ABS;
            end
            S_INC_ABS: begin
                cmd.ld_x = 1'b1;
                n_state  = S_DIV_HI;
            end
            S_DIV_HI: begin
                cmd.mul_sel = MUL_DIV_HI;
                n_state     = S_DIV_LO;
            end
            S_DIV_LO: begin
                cmd.mul_sel = MUL_DIV_LO;
                cmd.acc_op  = ACC_DIV;
                n_state     = S_DIV_SUM;
            end
            S_DIV_SUM: begin
                cmd.acc_op = ACC_ADD;
                n_state    = S_INC;
            end
            S_INC: begin
                cmd.ld_inc = 1'b1;
                n_state    = S_HEAD;
            end
            S_HEAD: begin
                cmd.ld_head = out_free;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.ld_head) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

`ifndef NO_ASSERTIONS
    a_short_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_command || !i_sample_ok)) |=> (r_state == S_HEAD))
        else $error("reset command or failed read did not skip the filter");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_HEAD))
        else $error("result raised outside the heading step");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HEAD && r_out_valid && !i_out_ready) |=> (r_state == S_HEAD))
        else $error("pending result overwritten");
`endif

endmodule

>>> hdl/gyro_yaw_tracker_core.sv
// Gyro yaw tracker top level: APB registers, controller and datapath.
// Depends on gyt_pkg, gyt_regs, gyt_ctrl and gyt_dp.
//
// Input channel (i_in_valid/o_in_ready) carries one item per transfer: a
// command bit (1 clears the heading), a Q6.16 z rate in rad/s, a read-ok
// flag and the elapsed milliseconds. Each transfer yields exactly one result
// on the output channel (o_out_valid/i_out_ready): the deadzoned rate in
// deg/s (Q12.16) and the heading in degrees (Q8.16, within +-180).
// A gyro sample steps through every controller state from input transfer to
// result; a heading reset or a failed read goes straight to the heading
// step. The steps come from one shared 32x20 multiplier that serves seven
// products per sample (rad-to-deg, filter, rate times time, divide by 1000)
// plus the accumulate and round steps.
// o_in_ready is high only while no item is in progress; one finished result
// may wait in the output register while the next item runs. If the receiver
// stalls, the following result holds in its final step until the slot frees.
// Synchronous reset clears the filter state, the heading and the valid flag
// and restores register defaults (offset 0, gain 0.9, deadzone 1.975 deg/s).
// Registers are written through APB at byte addresses 0, 4 and 8.
module gyro_yaw_tracker_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_command,
    input  logic signed [gyt_pkg::GYRO_W-1:0]   i_gyro_rate,
    input  logic                                i_sample_ok,
    input  logic [gyt_pkg::ELAPSED_W-1:0]       i_elapsed_ms,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [gyt_pkg::RATE_W-1:0]   o_turn_rate,
    output logic signed [gyt_pkg::ANGLE_W-1:0]  o_heading,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gyt_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import gyt_pkg::*;

    t_cfg    cfg;
    t_dp_cmd dp_cmd;

    gyt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gyt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_sample_ok (i_sample_ok),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd)
    );

    gyt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_cfg        (cfg),
        .i_gyro_rate  (i_gyro_rate),
        .i_elapsed_ms (i_elapsed_ms),
        .o_turn_rate  (o_turn_rate),
        .o_heading    (o_heading)
    );

endmodule
